>>> hw/rtl/event_log_overwrite_ring_macros.svh
// ----------------------------------------------------------------------------
// Event log assertion macros
// Shared concurrent assertion forms for the event log checker.
// ----------------------------------------------------------------------------
`ifndef EVENT_LOG_OVERWRITE_RING_MACROS_SVH
`define EVENT_LOG_OVERWRITE_RING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELOR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELOR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/elor_pkg.sv
// ----------------------------------------------------------------------------
// Event log package
// Transaction types, operation codes and status codes of the event log.
// ----------------------------------------------------------------------------
`default_nettype none

package elor_pkg;

	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_POP    = 2'd1;
	localparam logic [1:0] KIND_PEEK   = 2'd2;

	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_REJECT = 2'd1;
	localparam logic [1:0] STATUS_EMPTY  = 2'd2;

	localparam logic [7:0] MAX_SEVERITY_RESET = 8'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] event_time;
		logic [31:0] event_value;
		logic [15:0] event_code;
		logic [7:0]  source_number;
		logic [7:0]  severity_level;
		logic [7:0]  peek_offset;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_timestamp;
		logic [31:0] out_value;
		logic [15:0] out_code;
		logic [7:0]  out_source;
		logic [7:0]  out_severity;
		logic [4:0]  fill_count;
		logic [31:0] overwrite_total;
		logic [31:0] record_total;
	} result_t;

	typedef struct packed {
		logic [63:0] ts;
		logic [31:0] val;
		logic [15:0] code;
		logic [7:0]  src;
		logic [7:0]  sev;
	} entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/event_log_overwrite_ring.sv
// ----------------------------------------------------------------------------
// Event log with overwrite-oldest ring store
// Records, pops and peeks diagnostic events in a circular store.
// ----------------------------------------------------------------------------
// Each accepted transaction is one operation: record, pop oldest, or peek at
// an offset from the oldest entry. The block takes one transaction per cycle
// while the result side is not stalled, and returns exactly one result per
// transaction: the transaction is held in an input register, and when it
// advances the pointer and count update, the store read mux and the store
// write all complete in a single step, with the result in the result
// register. A full store drops its oldest entry on a successful record. The
// store holds no reset; only entries that were recorded are ever returned.
`default_nettype none

module event_log_overwrite_ring #(
	parameter int LOG_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire elor_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output elor_pkg::result_t     result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [7:0]       cfg_data
);

	localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int ADD_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	elor_pkg::entry_t  store_q [LOG_DEPTH];
	logic [PTR_W-1:0]  oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       dropped_q;
	logic [31:0]       recorded_q;
	logic [7:0]        max_sev_q;

	logic              valid_s1;
	elor_pkg::item_t   item_s1;
	logic              result_valid_q;
	elor_pkg::result_t result_q;

	logic              advance;
	logic              full;
	logic              hit;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_slot;
	logic [PTR_W-1:0]  rd_idx;
	logic [PTR_W-1:0]  oldest_inc;
	logic [PTR_W-1:0]  oldest_d;
	logic [CNT_W-1:0]  count_d;
	logic [31:0]       dropped_d;
	logic [31:0]       recorded_d;
	logic [1:0]        status_d;
	elor_pkg::entry_t  rd_entry;
	elor_pkg::entry_t  wr_entry;
	elor_pkg::result_t result_d;

	function automatic logic [PTR_W-1:0] wrap_idx(input logic [ADD_W-1:0] s);
		if (s >= ADD_W'(LOG_DEPTH)) begin
			return PTR_W'(s - ADD_W'(LOG_DEPTH));
		end
		return PTR_W'(s);
	endfunction

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign full       = (count_q == CNT_W'(LOG_DEPTH));
	assign oldest_inc = (oldest_q == PTR_W'(LOG_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);
	assign rd_entry   = store_q[rd_idx];

	assign wr_entry.ts   = item_s1.event_time;
	assign wr_entry.val  = item_s1.event_value;
	assign wr_entry.code = item_s1.event_code;
	assign wr_entry.src  = item_s1.source_number;
	assign wr_entry.sev  = item_s1.severity_level;

	always_comb begin
		oldest_d   = oldest_q;
		count_d    = count_q;
		dropped_d  = dropped_q;
		recorded_d = recorded_q;
		wr_en      = 1'b0;
		wr_slot    = full ? oldest_q : wrap_idx(ADD_W'(oldest_q) + ADD_W'(count_q));
		rd_idx     = oldest_q;
		hit        = 1'b0;
		status_d   = elor_pkg::STATUS_REJECT;
		unique case (item_s1.kind)
			elor_pkg::KIND_RECORD: begin
				if (item_s1.event_code != 16'd0 && item_s1.severity_level <= max_sev_q) begin
					wr_en      = 1'b1;
					status_d   = elor_pkg::STATUS_DONE;
					recorded_d = recorded_q + 32'd1;
					if (full) begin
						oldest_d  = oldest_inc;
						dropped_d = dropped_q + 32'd1;
					end else begin
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			elor_pkg::KIND_POP: begin
				if (count_q == '0) begin
					status_d = elor_pkg::STATUS_EMPTY;
				end else begin
					hit      = 1'b1;
					status_d = elor_pkg::STATUS_DONE;
					oldest_d = oldest_inc;
					count_d  = count_q - CNT_W'(1);
				end
			end
			elor_pkg::KIND_PEEK: begin
				rd_idx = wrap_idx(ADD_W'(oldest_q) + ADD_W'(item_s1.peek_offset));
				if (CMP_W'(item_s1.peek_offset) >= CMP_W'(count_q)) begin
					status_d = elor_pkg::STATUS_EMPTY;
				end else begin
					hit      = 1'b1;
					status_d = elor_pkg::STATUS_DONE;
				end
			end
			default: begin
				status_d = elor_pkg::STATUS_REJECT;
			end
		endcase

		result_d.status          = status_d;
		result_d.out_timestamp   = hit ? rd_entry.ts : 64'd0;
		result_d.out_value       = hit ? rd_entry.val : 32'd0;
		result_d.out_code        = hit ? rd_entry.code : 16'd0;
		result_d.out_source      = hit ? rd_entry.src : 8'd0;
		result_d.out_severity    = hit ? rd_entry.sev : 8'd0;
		result_d.fill_count      = 5'(count_d);
		result_d.overwrite_total = dropped_d;
		result_d.record_total    = recorded_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			oldest_q       <= '0;
			count_q        <= '0;
			dropped_q      <= '0;
			recorded_q     <= '0;
			max_sev_q      <= elor_pkg::MAX_SEVERITY_RESET;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				oldest_q       <= oldest_d;
				count_q        <= count_d;
				dropped_q      <= dropped_d;
				recorded_q     <= recorded_d;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				max_sev_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= result_d;
		end
		if (advance && wr_en) begin
			store_q[wr_slot] <= wr_entry;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/elor_checker.sv
// ----------------------------------------------------------------------------
// Event log port checker
// Port-level assertions for the event log, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_log_overwrite_ring_macros.svh"

module elor_checker #(
	parameter int LOG_DEPTH = 16
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire elor_pkg::result_t result
);

	`ELOR_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

	`ELOR_ASSERT_SAME(a_status_code, clk, arst_n, result_valid, result.status == elor_pkg::STATUS_DONE || result.status == elor_pkg::STATUS_REJECT || result.status == elor_pkg::STATUS_EMPTY, "undefined status code")

	`ELOR_ASSERT_SAME(a_fail_zero, clk, arst_n, result_valid && result.status != elor_pkg::STATUS_DONE, result.out_timestamp == 64'd0 && result.out_value == 32'd0 && result.out_code == 16'd0 && result.out_source == 8'd0 && result.out_severity == 8'd0, "failed operation returned entry data")

	`ELOR_ASSERT_SAME(a_fill_bound, clk, arst_n, result_valid, LOG_DEPTH > 31 || 32'(result.fill_count) <= 32'(LOG_DEPTH), "fill count above depth")

endmodule

bind event_log_overwrite_ring elor_checker #(
	.LOG_DEPTH(LOG_DEPTH)
) u_elor_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

`default_nettype wire
